/* sv/adpcm_pkg.sv */
// Shared types and constants for the ADPCM frame decoder.
`default_nettype none
package adpcm_pkg;

  localparam int unsigned PredictorsDef = 8;
  localparam int unsigned InDataW       = 72;
  localparam int unsigned FracBits      = 11;
  localparam int unsigned AccW          = 36;

  typedef enum logic [1:0] {
    K_BOOK  = 2'd0,
    K_LOOP  = 2'd1,
    K_START = 2'd2,
    K_DATA  = 2'd3
  } kind_t;

  // start mode bits: bit 0 clears history, bit 1 takes the loop pair
  localparam int unsigned ModeZeroBit = 0;
  localparam int unsigned ModeLoopBit = 1;

  typedef struct packed {
    kind_t              kind;
    logic               book_ok;
    logic [6:0]         book_address;
    logic signed [15:0] book_word;
    logic [1:0]         start_mode;
    logic signed [15:0] history_newer;
    logic signed [15:0] history_older;
    logic [7:0]         data_byte;
  } item_t;

endpackage
`default_nettype wire

/* sv/adpcm_front.sv */
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none
module adpcm_front #(
  parameter int unsigned PREDICTORS = adpcm_pkg::PredictorsDef
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [adpcm_pkg::InDataW-1:0]   in_tdata,
  input  wire [1:0]                      in_tuser,
  output logic                           q_valid,
  output adpcm_pkg::item_t               q_item,
  input  wire                            q_pop
);
  import adpcm_pkg::*;

  localparam int unsigned BookDepth = PREDICTORS * 16;

  item_t      slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      it;
  logic       push, pop;

  always_comb begin
    it.kind          = kind_t'(in_tuser);
    it.book_address  = in_tdata[6:0];
    it.book_word     = in_tdata[22:7];
    it.start_mode    = in_tdata[24:23];
    it.history_newer = in_tdata[40:25];
    it.history_older = in_tdata[56:41];
    it.data_byte     = in_tdata[64:57];
    // loads past the end of the book are dropped
    it.book_ok       = ({25'd0, in_tdata[6:0]} < 32'(BookDepth));
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= it;
  end

endmodule
`default_nettype wire

/* sv/adpcm_back.sv */
// Back end: executes queued items, runs the tap MAC and drives the result register.
`default_nettype none
module adpcm_back #(
  parameter int unsigned PREDICTORS = adpcm_pkg::PredictorsDef
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  adpcm_pkg::item_t   q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);
  import adpcm_pkg::*;

  localparam int unsigned BookDepth = PREDICTORS * 16;
  localparam int unsigned BookAw    = $clog2(BookDepth);

  typedef enum logic [2:0] {S_FETCH, S_SETUP, S_MAC, S_DRAIN, S_EMIT} state_t;

  state_t             st_r, st_nxt;
  logic signed [15:0] book [BookDepth];
  logic signed [15:0] loop_n_r, loop_o_r, rec_n_r, rec_o_r, base_n_r, base_o_r;
  logic signed [15:0] res_r [8];
  logic [3:0]         pos_r, shift_r;
  logic [2:0]         pred_r;
  logic [7:0]         byte_r;
  logic [1:0]         jhi_r;
  logic               s_r;
  logic [3:0]         t_r;
  logic               v1_r, v2_r, pz_r;
  logic signed [15:0] rd_r, op1_r;
  logic signed [31:0] prod_r;
  logic signed [AccW-1:0] acc_r;
  logic               ov_r, olast_r, oend_r;
  logic signed [15:0] osample_r;

  logic [2:0]         j;
  logic [3:0]         nib;
  logic signed [15:0] resid;
  logic               issue;
  logic               ord;
  logic [2:0]         tap;
  logic [6:0]         raddr;
  logic signed [15:0] opnd;
  logic signed [15:0] coefv;
  logic signed [AccW-FracBits-1:0] qv;
  logic signed [15:0] sat;
  logic               out_free;

  assign j        = {jhi_r, s_r};
  assign nib      = s_r ? byte_r[3:0] : byte_r[7:4];
  assign resid    = 16'({{12{nib[3]}}, nib} << shift_r);
  assign issue    = (st_r == S_MAC);
  assign out_free = !ov_r || out_tready;
  assign q_pop    = (st_r == S_FETCH) && q_valid;

  // term 0: order 0 tap j on older base; term 1: order 1 tap j on newer base;
  // term t>=2: order 1 tap j-t+1 on residual t-2
  always_comb begin
    ord  = (t_r != 4'd0);
    tap  = (t_r < 4'd2) ? j : 3'(j - t_r[2:0] + 3'd1);
    raddr = {pred_r, ord, tap};
    if (t_r == 4'd0)      opnd = base_o_r;
    else if (t_r == 4'd1) opnd = base_n_r;
    else                  opnd = res_r[3'(t_r - 4'd2)];
  end

  assign coefv = pz_r ? 16'sd0 : rd_r;

  always_comb begin
    qv = (AccW-FracBits)'(acc_r >>> FracBits);
    if (qv < -25'sd32768)     sat = 16'sh8000;
    else if (qv > 25'sd32767) sat = 16'sh7fff;
    else                      sat = 16'(qv);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_FETCH: if (q_valid && q_item.kind == K_DATA && pos_r != 4'd0) st_nxt = S_SETUP;
      S_SETUP: st_nxt = S_MAC;
      S_MAC:   if (t_r == {1'b0, j} + 4'd1) st_nxt = S_DRAIN;
      S_DRAIN: if (!v1_r && !v2_r) st_nxt = S_EMIT;
      S_EMIT:  if (out_free) st_nxt = s_r ? S_FETCH : S_SETUP;
      default: st_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == K_BOOK && q_item.book_ok)
      book[q_item.book_address[BookAw-1:0]] <= q_item.book_word;
    rd_r <= book[raddr[BookAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_FETCH;
      loop_n_r <= '0; loop_o_r <= '0; rec_n_r <= '0; rec_o_r <= '0;
      base_n_r <= '0; base_o_r <= '0;
      for (int i = 0; i < 8; i++) res_r[i] <= '0;
      pos_r <= '0; shift_r <= '0; pred_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; ov_r <= 1'b0;
      s_r <= 1'b0; t_r <= '0; jhi_r <= '0;
    end else begin
      st_r <= st_nxt;
      // a new sample in S_EMIT reloads the register instead
      if (ov_r && out_tready && st_r != S_EMIT) ov_r <= 1'b0;
      v1_r   <= issue;
      v2_r   <= v1_r;
      op1_r  <= opnd;
      pz_r   <= ({29'd0, pred_r} >= 32'(PREDICTORS));
      prod_r <= coefv * op1_r;
      if (v2_r) acc_r <= acc_r + AccW'(prod_r);
      if (issue) t_r <= t_r + 4'd1;
      unique case (st_r)
        S_FETCH: if (q_valid) begin
          unique case (q_item.kind)
            K_BOOK: ;
            K_LOOP: begin
              loop_n_r <= q_item.history_newer;
              loop_o_r <= q_item.history_older;
            end
            K_START: begin
              pos_r <= '0;
              if (q_item.start_mode[ModeZeroBit]) begin
                rec_n_r <= '0; rec_o_r <= '0; base_n_r <= '0; base_o_r <= '0;
              end else if (q_item.start_mode[ModeLoopBit]) begin
                rec_n_r <= loop_n_r; rec_o_r <= loop_o_r;
                base_n_r <= loop_n_r; base_o_r <= loop_o_r;
              end else begin
                rec_n_r <= q_item.history_newer; rec_o_r <= q_item.history_older;
                base_n_r <= q_item.history_newer; base_o_r <= q_item.history_older;
              end
            end
            K_DATA: begin
              if (pos_r == 4'd0) begin
                shift_r <= q_item.data_byte[7:4];
                pred_r  <= q_item.data_byte[2:0];
                pos_r   <= 4'd1;
              end else begin
                if (pos_r == 4'd1 || pos_r == 4'd5) begin
                  base_n_r <= rec_n_r; base_o_r <= rec_o_r;
                end
                byte_r <= q_item.data_byte;
                jhi_r  <= 2'(pos_r - 4'd1);
                s_r    <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_SETUP: begin
          res_r[j] <= resid;
          acc_r    <= AccW'(resid) <<< FracBits;
          t_r      <= '0;
        end
        S_MAC, S_DRAIN: ;
        S_EMIT: if (out_free) begin
          ov_r      <= 1'b1;
          osample_r <= sat;
          olast_r   <= s_r;
          oend_r    <= s_r && (pos_r == 4'd8);
          rec_n_r   <= sat;
          rec_o_r   <= rec_n_r;
          if (s_r) pos_r <= (pos_r == 4'd8) ? 4'd0 : pos_r + 4'd1;
          else     s_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = osample_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oend_r;

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_FETCH) |-> !q_pop) else $error("queue popped while busy");
  a_mac_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MAC) |-> (pos_r != 4'd0)) else $error("MAC without a frame");
  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MAC) |-> (t_r <= {1'b0, j} + 4'd1)) else $error("term count overrun");
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> (!v1_r && !v2_r)) else $error("emit with MAC in flight");

endmodule
`default_nettype wire

/* sv/adpcm_frame_decoder.sv */
// Top level of the ADPCM frame decoder: front queue plus MAC back end.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata item fields, tuser func
//  out_    | out | out_tvalid/out_tready | tdata sample, tlast, tuser frame end
//
// Loads, starts and headers are handled in the back end's fetch state. A data byte
// takes one fetch and two samples; the sample at group index j needs j+2
// codebook reads plus setup, a drain and emit. The single codebook read port
// and one multiplier serialize these steps, and the back end takes no new byte
// until both samples of the last are emitted. The front queue holds two items,
// so up to two items are accepted while the back end computes. Reset is synchronous and
// active low; the codebook is not cleared and must be loaded before use.
`default_nettype none
module adpcm_frame_decoder #(
  parameter int unsigned PREDICTORS = adpcm_pkg::PredictorsDef
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // [6:0] book_address, [22:7] book_word, [24:23] start_mode,
  // [40:25] history_newer, [56:41] history_older, [64:57] data_byte, rest 0
  input  wire [adpcm_pkg::InDataW-1:0] in_tdata,
  input  wire [1:0]                    in_tuser,   // func
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [15:0]                  out_tdata,  // sample
  output logic                         out_tlast,  // last_of_run
  output logic                         out_tuser   // frame_end
);
  import adpcm_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  adpcm_front #(.PREDICTORS(PREDICTORS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_item, .q_pop
  );

  adpcm_back #(.PREDICTORS(PREDICTORS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule
`default_nettype wire
